>>> sv/adpcm_pkg.sv
// shared types, constants and codes of the adpcm decoder
package adpcm_pkg;

  localparam int unsigned CoefW       = 16;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned ShiftW      = 4;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned HistW       = 32;
  localparam int unsigned NumCoefRegs = 4;
  localparam int unsigned PosW        = 3;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [ShiftW-1:0] MaxShift       = 4'd15;
  localparam logic [PosW-1:0]   FrameDataBytes = 3'd7;
  localparam int unsigned       PredShift      = 11;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_COEF_01 = 3'd0,
    CFG_COEF_23 = 3'd1,
    CFG_COEF_45 = 3'd2,
    CFG_COEF_67 = 3'd3,
    CFG_HIST    = 3'd4
  } cfg_idx_e;

  typedef logic [NumCoefRegs-1:0][CfgDataW-1:0] coef_bank_t;

  // command kinds from front to back
  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_DATA   = 2'd1,
    OP_ERROR  = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ByteW-1:0]  data;
    logic              last;
    logic [CoefW-1:0]  coef_one;
    logic [CoefW-1:0]  coef_two;
    logic [ShiftW-1:0] shift;
    logic              load_hist;
    logic [HistW-1:0]  hist;
  } cmd_t;

endpackage

>>> sv/adpcm_in_if.sv
// input channel: encoded stream words
interface adpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

>>> sv/adpcm_out_if.sv
// output channel: decoded sample pairs and error flags
interface adpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_first;
  logic signed [15:0] sample_second;
  logic               frame_end;
  logic               header_error;

  modport source (output valid, output sample_first, output sample_second,
                  output frame_end, output header_error, input ready);
  modport sink   (input valid, input sample_first, input sample_second,
                  input frame_end, input header_error, output ready);
endinterface

>>> sv/adpcm_fifo.sv
// small command queue between front and back
module adpcm_fifo #(
  parameter int unsigned Depth = adpcm_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  adpcm_pkg::cmd_t   push_data_i,
  input  logic              pop_i,
  output adpcm_pkg::cmd_t   pop_data_o,
  output logic              full_o,
  output logic              empty_o
);
  import adpcm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end
endmodule

>>> sv/adpcm_front.sv
// front end: accepts words, tracks frame position and error hold, builds commands
module adpcm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  adpcm_in_if.sink                     in_i,
  input  adpcm_pkg::coef_bank_t        coef_i,
  input  logic [adpcm_pkg::HistW-1:0]  hist_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output adpcm_pkg::cmd_t              cmd_o
);
  import adpcm_pkg::*;

  logic [PosW-1:0]     pos_q, pos_d, pos_cur;
  logic                err_q, err_d, err_cur;
  logic                accept;
  logic [3:0]          pred;
  logic [ShiftW-1:0]   sh;
  logic                illegal;
  logic [CfgDataW-1:0] coef_reg;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;

  // a start word restarts the frame and clears the hold
  assign pos_cur = in_i.stream_start ? '0 : pos_q;
  assign err_cur = in_i.stream_start ? 1'b0 : err_q;

  assign pred     = in_i.data_byte[7:4];
  assign sh       = in_i.data_byte[3:0];
  assign illegal  = pred[3] || (sh == MaxShift);
  assign coef_reg = coef_i[pred[2:1]];

  always_comb begin
    pos_d            = pos_q;
    err_d            = err_q;
    push_o           = 1'b0;
    cmd_o.op         = OP_DATA;
    cmd_o.data       = in_i.data_byte;
    cmd_o.last       = (pos_cur == FrameDataBytes);
    cmd_o.coef_one   = pred[0] ? coef_reg[47:32] : coef_reg[15:0];
    cmd_o.coef_two   = pred[0] ? coef_reg[63:48] : coef_reg[31:16];
    cmd_o.shift      = sh;
    cmd_o.load_hist  = in_i.stream_start;
    cmd_o.hist       = hist_i;
    if (accept) begin
      pos_d = pos_cur;
      err_d = err_cur;
      if (!err_cur) begin
        push_o = 1'b1;
        if (pos_cur == '0) begin
          if (illegal) begin
            cmd_o.op = OP_ERROR;
            err_d    = 1'b1;
          end else begin
            cmd_o.op = OP_HEADER;
            pos_d    = PosW'(1);
          end
        end else begin
          cmd_o.op = OP_DATA;
          pos_d    = (pos_cur == FrameDataBytes) ? '0 : pos_cur + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      err_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      err_q <= err_d;
    end
  end
endmodule

>>> sv/adpcm_back.sv
// back end: predictor datapath, history and output register
module adpcm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  adpcm_pkg::cmd_t   cmd_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  adpcm_out_if.source       out_o
);
  import adpcm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL_HI = 5'b00010,
    ST_ADD_HI = 5'b00100,
    ST_MUL_LO = 5'b01000,
    ST_ADD_LO = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic signed [CoefW-1:0]   coef_one_q, coef_two_q;
  logic [ShiftW-1:0]         shift_q;
  logic signed [SampleW-1:0] prev_q, pprev_q;
  logic [ByteW-1:0]          byte_q;
  logic                      last_q;
  logic signed [31:0]        prod_one_q, prod_two_q;

  logic                      out_valid_q;
  logic signed [SampleW-1:0] first_q, second_q;
  logic                      frame_end_q, error_q;
  logic                      out_free;

  logic signed [32:0]        acc;
  logic signed [21:0]        pred;
  logic signed [3:0]         code;
  logic signed [17:0]        scaled;
  logic signed [22:0]        sum;
  logic signed [SampleW-1:0] sample;

  assign out_free = !out_valid_q || out_o.ready;

  // rounded two-tap prediction, floor shift
  assign acc    = 33'(prod_one_q) + 33'(prod_two_q) + 33'sd1024;
  assign pred   = acc[32:PredShift];
  assign code   = state_q[2] ? byte_q[7:4] : byte_q[3:0];
  assign scaled = 18'(code) <<< shift_q;
  assign sum    = 23'(pred) + 23'(scaled);

  always_comb begin
    if (sum < -23'sd32768) begin
      sample = 16'sh8000;
    end else if (sum > 23'sd32767) begin
      sample = 16'sh7fff;
    end else begin
      sample = sum[SampleW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          unique case (cmd_i.op)
            OP_HEADER: pop_o = 1'b1;
            OP_ERROR:  pop_o = out_free;
            OP_DATA: begin
              pop_o = out_free;
              if (out_free) begin
                state_d = ST_MUL_HI;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      ST_MUL_HI: state_d = ST_ADD_HI;
      ST_ADD_HI: state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_ADD_LO;
      ST_ADD_LO: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      coef_one_q  <= '0;
      coef_two_q  <= '0;
      shift_q     <= '0;
      prev_q      <= '0;
      pprev_q     <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        unique case (cmd_i.op)
          OP_HEADER: begin
            coef_one_q <= cmd_i.coef_one;
            coef_two_q <= cmd_i.coef_two;
            shift_q    <= cmd_i.shift;
            if (cmd_i.load_hist) begin
              prev_q  <= cmd_i.hist[15:0];
              pprev_q <= cmd_i.hist[31:16];
            end
          end
          OP_ERROR:  out_valid_q <= 1'b1;
          OP_DATA:   ;
          default:   ;
        endcase
      end
      if (state_q == ST_ADD_HI || state_q == ST_ADD_LO) begin
        prev_q  <= sample;
        pprev_q <= prev_q;
      end
      if (state_q == ST_ADD_LO) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // datapath and payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.op == OP_DATA) begin
      byte_q <= cmd_i.data;
      last_q <= cmd_i.last;
    end
    if (state_q == ST_MUL_HI || state_q == ST_MUL_LO) begin
      prod_one_q <= 32'(coef_one_q) * 32'(prev_q);
      prod_two_q <= 32'(coef_two_q) * 32'(pprev_q);
    end
    if (pop_o && cmd_i.op == OP_ERROR) begin
      first_q     <= '0;
      second_q    <= '0;
      frame_end_q <= 1'b0;
      error_q     <= 1'b1;
    end
    if (state_q == ST_ADD_HI) begin
      first_q <= sample;
    end
    if (state_q == ST_ADD_LO) begin
      second_q    <= sample;
      frame_end_q <= last_q;
      error_q     <= 1'b0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.sample_first  = first_q;
  assign out_o.sample_second = second_q;
  assign out_o.frame_end     = frame_end_q;
  assign out_o.header_error  = error_q;
endmodule

>>> sv/dsp_adpcm_decoder.sv
// top level: 4-bit adpcm decoder with config registers, front end, queue and back end
// a data word is queued, dispatched from idle once the output register is free, and its pair
// is registered after the back end sequencer steps through mul_hi, add_hi, mul_lo and add_lo
// (two multiply and two accumulate states per byte); new data words dispatch only from idle
// header words are popped from idle without the sequencer; words in error hold are never queued
// reset: asynchronous active low, clears config registers, history and frame state
module dsp_adpcm_decoder #(
  parameter int unsigned QueueDepth = adpcm_pkg::QueueDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  adpcm_in_if.sink                       in_i,
  adpcm_out_if.source                    out_o,
  input  logic                           cfg_we_i,
  input  logic [adpcm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [adpcm_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import adpcm_pkg::*;

  // coefficient bank, two predictors per register
  coef_bank_t       coef_q;
  // initial history: prev in low half, prev-prev in high half
  logic [HistW-1:0] hist_q;

  // queue handshake between front and back
  logic q_push, q_pop, q_full, q_empty;
  cmd_t front_cmd, back_cmd;

  // config writes, indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      hist_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEF_01: coef_q[0] <= cfg_wdata_i;
        CFG_COEF_23: coef_q[1] <= cfg_wdata_i;
        CFG_COEF_45: coef_q[2] <= cfg_wdata_i;
        CFG_COEF_67: coef_q[3] <= cfg_wdata_i;
        CFG_HIST:    hist_q    <= cfg_wdata_i[HistW-1:0];
        default:     ;
      endcase
    end
  end

  // front: classifies header / data words, holds off after a bad header
  adpcm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .coef_i   (coef_q),
    .hist_i   (hist_q),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (front_cmd)
  );

  // decouples word acceptance from the slower sample datapath
  adpcm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_cmd),
    .pop_i       (q_pop),
    .pop_data_o  (back_cmd),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // back: predictor, clamp, history update and output register
  adpcm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (back_cmd),
    .q_empty_i (q_empty),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );
endmodule
